// ===== rtl/envelope_stereo_wet_dry_mixer_top_assert.svh =====
// ----------------------------------------------------------------------------
// envelope stereo wet/dry mixer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef ENVELOPE_STEREO_WET_DRY_MIXER_TOP_ASSERT_SVH
`define ENVELOPE_STEREO_WET_DRY_MIXER_TOP_ASSERT_SVH

// overlapping implication, consequent may carry its own constant delay
`define ESWDM_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> cons) \
    else $error("eswdm assertion failed");

// implication checked in the next cycle
`define ESWDM_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("eswdm assertion failed");

`endif

// ===== rtl/eswdm_pkg.sv =====
// ----------------------------------------------------------------------------
// eswdm_pkg
// types and constants shared by the mixer controller and datapath
// ----------------------------------------------------------------------------
package eswdm_pkg;

  localparam int SMP_W  = 16;
  localparam int ENV_W  = 16;
  localparam int FLAG_W = 5;
  localparam int IDX_W  = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ENV_DL  = 3'd0;
  localparam logic [IDX_W-1:0] REG_ENV_DR  = 3'd1;
  localparam logic [IDX_W-1:0] REG_ENV_WET = 3'd2;
  localparam logic [IDX_W-1:0] REG_STEP_DL = 3'd3;
  localparam logic [IDX_W-1:0] REG_STEP_DR = 3'd4;
  localparam logic [IDX_W-1:0] REG_STEP_WT = 3'd5;
  localparam logic [IDX_W-1:0] REG_FLAGS   = 3'd6;

  // mix flag bit positions
  localparam int FLAG_DRY_R = 0;
  localparam int FLAG_DRY_L = 1;
  localparam int FLAG_WET_R = 2;
  localparam int FLAG_WET_L = 3;
  localparam int FLAG_SWAP  = 4;

  // inversion masks
  localparam logic [SMP_W-1:0] MASK_DRY   = 16'hFFFF;
  localparam logic [SMP_W-1:0] MASK_WET_L = 16'hFFFC;
  localparam logic [SMP_W-1:0] MASK_WET_R = 16'hFFFE;

  // controller to datapath commands
  typedef struct packed {
    logic cap_in;
    logic dry;
    logic wet;
    logic load_out;
  } eswdm_cmd_t;

  function automatic logic [SMP_W-1:0] sat_add16(logic signed [SMP_W-1:0] a,
                                                 logic signed [SMP_W-1:0] b);
    logic signed [SMP_W:0] s;
    s = {a[SMP_W-1], a} + {b[SMP_W-1], b};
    if (s[SMP_W] != s[SMP_W-1]) begin
      return s[SMP_W] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
    end
    return s[SMP_W-1:0];
  endfunction

endpackage

// ===== rtl/eswdm_ctrl.sv =====
// ----------------------------------------------------------------------------
// eswdm_ctrl
// sequencer for capture, dry scale, wet scale and result load
// ----------------------------------------------------------------------------
module eswdm_ctrl
  import eswdm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output eswdm_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DRY  = 4'b0010,
    ST_WET  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_next = ST_DRY;
        end
      end
      ST_DRY: begin
        cmd.dry    = 1'b1;
        state_next = ST_WET;
      end
      ST_WET: begin
        cmd.wet    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/eswdm_datapath.sv =====
// ----------------------------------------------------------------------------
// eswdm_datapath
// registers, envelopes, scaling multipliers and saturating adders
// ----------------------------------------------------------------------------
module eswdm_datapath
  import eswdm_pkg::*;
#(
  parameter int GROUP_SIZE = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  eswdm_cmd_t              cmd,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [ENV_W-1:0]        cfg_data,
  input  logic signed [SMP_W-1:0] sample,
  input  logic signed [SMP_W-1:0] dry_left_acc,
  input  logic signed [SMP_W-1:0] dry_right_acc,
  input  logic signed [SMP_W-1:0] wet_left_acc,
  input  logic signed [SMP_W-1:0] wet_right_acc,
  input  logic                    block_end,
  output logic signed [SMP_W-1:0] dry_left_sum,
  output logic signed [SMP_W-1:0] dry_right_sum,
  output logic signed [SMP_W-1:0] wet_left_sum,
  output logic signed [SMP_W-1:0] wet_right_sum
);

  localparam int POS_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(GROUP_SIZE - 1);

  // configuration
  logic [ENV_W-1:0]  start_dl, start_dr, start_wet;
  logic [ENV_W-1:0]  step_dl, step_dr, step_wet;
  logic [FLAG_W-1:0] flags;
  logic              reload;

  // running state
  logic [ENV_W-1:0] env_dl, env_dr, env_wet;
  logic [POS_W-1:0] pos;
  logic             group_done;

  // item registers
  logic signed [SMP_W-1:0] smp_q, acc_dl_q, acc_dr_q, acc_wl_q, acc_wr_q;
  logic                    blk_q;
  logic signed [SMP_W-1:0] dry_l_q, dry_r_q, wet_l_q, wet_r_q;

  logic signed [2*SMP_W:0] p_dl, p_dr, p_wl, p_wr;
  logic [SMP_W-1:0]        m_dl, m_dr, m_wl, m_wr;
  logic signed [SMP_W-1:0] wl_src, wr_src;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_dl  <= '0;
      start_dr  <= '0;
      start_wet <= '0;
      step_dl   <= '0;
      step_dr   <= '0;
      step_wet  <= '0;
      flags     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENV_DL:  start_dl  <= cfg_data;
        REG_ENV_DR:  start_dr  <= cfg_data;
        REG_ENV_WET: start_wet <= cfg_data;
        REG_STEP_DL: step_dl   <= cfg_data;
        REG_STEP_DR: step_dr   <= cfg_data;
        REG_STEP_WT: step_wet  <= cfg_data;
        REG_FLAGS:   flags     <= cfg_data[FLAG_W-1:0];
        default:     ;
      endcase
    end
  end

  // a write to any listed register asks for an envelope reload next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      reload <= 1'b0;
    end else begin
      reload <= cfg_we && (cfg_index <= REG_FLAGS);
    end
  end

  assign group_done = (pos == POS_LAST) || blk_q;

  // envelopes reload through the registered reload flag, stepping follows the wet scale
  always_ff @(posedge clk) begin
    if (rst) begin
      env_dl  <= '0;
      env_dr  <= '0;
      env_wet <= '0;
      pos     <= '0;
    end else if (reload) begin
      env_dl  <= start_dl;
      env_dr  <= start_dr;
      env_wet <= start_wet;
    end else if (cmd.wet) begin
      if (group_done) begin
        pos     <= '0;
        env_dl  <= env_dl + step_dl;
        env_dr  <= env_dr + step_dr;
        env_wet <= env_wet + step_wet;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

  assign m_dl = flags[FLAG_DRY_L] ? MASK_DRY   : '0;
  assign m_dr = flags[FLAG_DRY_R] ? MASK_DRY   : '0;
  assign m_wl = flags[FLAG_WET_L] ? MASK_WET_L : '0;
  assign m_wr = flags[FLAG_WET_R] ? MASK_WET_R : '0;

  assign p_dl = smp_q   * $signed({1'b0, env_dl});
  assign p_dr = smp_q   * $signed({1'b0, env_dr});
  assign p_wl = dry_l_q * $signed({1'b0, env_wet});
  assign p_wr = dry_r_q * $signed({1'b0, env_wet});

  assign wl_src = flags[FLAG_SWAP] ? wet_r_q : wet_l_q;
  assign wr_src = flags[FLAG_SWAP] ? wet_l_q : wet_r_q;

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      smp_q    <= sample;
      acc_dl_q <= dry_left_acc;
      acc_dr_q <= dry_right_acc;
      acc_wl_q <= wet_left_acc;
      acc_wr_q <= wet_right_acc;
      blk_q    <= block_end;
    end
    if (cmd.dry) begin
      dry_l_q <= p_dl[2*SMP_W-1:SMP_W] ^ m_dl;
      dry_r_q <= p_dr[2*SMP_W-1:SMP_W] ^ m_dr;
    end
    if (cmd.wet) begin
      wet_l_q <= p_wl[2*SMP_W-1:SMP_W] ^ m_wl;
      wet_r_q <= p_wr[2*SMP_W-1:SMP_W] ^ m_wr;
    end
    if (cmd.load_out) begin
      dry_left_sum  <= sat_add16(acc_dl_q, dry_l_q);
      dry_right_sum <= sat_add16(acc_dr_q, dry_r_q);
      wet_left_sum  <= sat_add16(acc_wl_q, wl_src);
      wet_right_sum <= sat_add16(acc_wr_q, wr_src);
    end
  end

endmodule

// ===== rtl/envelope_stereo_wet_dry_mixer_top.sv =====
// ----------------------------------------------------------------------------
// envelope_stereo_wet_dry_mixer_top
// envelope-scaled mono to stereo dry/wet mixer with saturating accumulation
// ----------------------------------------------------------------------------
// usage
// - the slave stream carries one mono sample and the four accumulator samples
//   at that position; tlast marks the final sample of a block
// - the master stream returns the four saturated accumulator sums per item
// - the user must write registers on the cfg port only while no item is in
//   flight, which the block does not enforce; any write to a listed register
//   reloads the three running envelopes from the start registers
// sequence
// - each item is captured, scaled dry, scaled wet, then its saturated sums
//   load into the output register once that register is free; the next
//   item is taken only after the result loads, so items go one at a time
// reset
// - synchronous; clears cfg registers, envelopes, group position and m_tvalid
// stall
// - a stalled result holds in the output register while the next item is
//   worked on; that item waits in its last step until the result is taken
// ----------------------------------------------------------------------------
module envelope_stereo_wet_dry_mixer_top
  import eswdm_pkg::*;
#(
  parameter int GROUP_SIZE = 8
) (
  input  logic              clk,
  input  logic              rst,
  // configuration write port
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [ENV_W-1:0]  cfg_data,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  // sample, dry_left_acc, dry_right_acc, wet_left_acc, wet_right_acc
  input  logic [79:0]       s_tdata,
  // block_end
  input  logic              s_tlast,
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  // dry_left_sum, dry_right_sum, wet_left_sum, wet_right_sum
  output logic [63:0]       m_tdata
);

  eswdm_cmd_t cmd;

  logic signed [SMP_W-1:0] dry_left_sum, dry_right_sum;
  logic signed [SMP_W-1:0] wet_left_sum, wet_right_sum;

  // sequencer: owns the handshakes and the output valid flag
  eswdm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  // datapath: registers, envelopes, multipliers, saturation
  eswdm_datapath #(
    .GROUP_SIZE (GROUP_SIZE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample        ($signed(s_tdata[15:0])),
    .dry_left_acc  ($signed(s_tdata[31:16])),
    .dry_right_acc ($signed(s_tdata[47:32])),
    .wet_left_acc  ($signed(s_tdata[63:48])),
    .wet_right_acc ($signed(s_tdata[79:64])),
    .block_end     (s_tlast),
    .dry_left_sum  (dry_left_sum),
    .dry_right_sum (dry_right_sum),
    .wet_left_sum  (wet_left_sum),
    .wet_right_sum (wet_right_sum)
  );

  assign m_tdata = {wet_right_sum, wet_left_sum, dry_right_sum, dry_left_sum};

endmodule

// ===== rtl/eswdm_checker.sv =====
// ----------------------------------------------------------------------------
// eswdm_checker
// port-level checks of the mixer, bound to the top level
// ----------------------------------------------------------------------------
`include "envelope_stereo_wet_dry_mixer_top_assert.svh"

module eswdm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  // a stalled result keeps its valid and its data
  `ESWDM_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // one item at a time: no transfer in the cycle after an input transfer
  `ESWDM_ASSERT_NXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready)

  // with the output register free, a result follows after the dry, wet and done states
  `ESWDM_ASSERT_IMP(a_latency, clk, rst, s_tvalid && s_tready && !m_tvalid, ##4 m_tvalid)

endmodule

bind envelope_stereo_wet_dry_mixer_top eswdm_checker u_eswdm_checker (.*);

// ===== tb/sv/mix_checker.sv =====
// ----------------------------------------------------------------------------
// mix_checker
// watches the register port and both streams of the wet/dry mixer, predicts
// the four saturated accumulator sums of every sample and compares each
// result transfer against the oldest outstanding prediction
// ----------------------------------------------------------------------------
module mix_checker
  import eswdm_pkg::*;
#(
  parameter int GROUP_SIZE = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [ENV_W-1:0] cfg_data,
  input  logic             s_tvalid,
  input  logic             s_tready,
  // sample, dry_left_acc, dry_right_acc, wet_left_acc, wet_right_acc
  input  logic [79:0]      s_tdata,
  // block_end
  input  logic             s_tlast,
  input  logic             m_tvalid,
  input  logic             m_tready,
  // dry_left_sum, dry_right_sum, wet_left_sum, wet_right_sum
  input  logic [63:0]      m_tdata,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [SMP_W-1:0] wet_right_acc;
    logic signed [SMP_W-1:0] wet_left_acc;
    logic signed [SMP_W-1:0] dry_right_acc;
    logic signed [SMP_W-1:0] dry_left_acc;
    logic signed [SMP_W-1:0] smp;
  } mix_in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] wet_right;
    logic signed [SMP_W-1:0] wet_left;
    logic signed [SMP_W-1:0] dry_right;
    logic signed [SMP_W-1:0] dry_left;
  } mix_sums_t;

  // register copies
  logic [ENV_W-1:0]  start_dl, start_dr, start_wet;
  logic [ENV_W-1:0]  step_dl, step_dr, step_wet;
  logic [FLAG_W-1:0] flags;
  // running envelopes and group position
  logic [ENV_W-1:0]  env_dl, env_dr, env_wet;
  int                group_pos;

  mix_sums_t expected_sums[$];
  int        fail_count;

  // upper half of the signed x unsigned product, then the inversion mask
  function automatic logic signed [SMP_W-1:0] env_scale(logic signed [SMP_W-1:0] x,
                                                        logic [ENV_W-1:0] env,
                                                        logic [SMP_W-1:0] mask);
    logic [31:0] prod;
    prod = {{16{x[SMP_W-1]}}, x} * {16'h0000, env};
    return prod[31:16] ^ mask;
  endfunction

  function automatic logic signed [SMP_W-1:0] clamp_add(logic signed [SMP_W-1:0] a,
                                                        logic signed [SMP_W-1:0] b);
    logic signed [SMP_W:0] s;
    s = {a[SMP_W-1], a} + {b[SMP_W-1], b};
    if (s > 17'sd32767) begin
      return 16'h7FFF;
    end
    if (s < -17'sd32768) begin
      return 16'h8000;
    end
    return s[SMP_W-1:0];
  endfunction

  function automatic mix_sums_t predict_sums(mix_in_t d);
    logic [SMP_W-1:0]        m_dl, m_dr, m_wl, m_wr;
    logic signed [SMP_W-1:0] dl, dr, wl, wr;
    mix_sums_t               r;
    m_dl = flags[FLAG_DRY_L] ? MASK_DRY : '0;
    m_dr = flags[FLAG_DRY_R] ? MASK_DRY : '0;
    m_wl = flags[FLAG_WET_L] ? MASK_WET_L : '0;
    m_wr = flags[FLAG_WET_R] ? MASK_WET_R : '0;
    dl = env_scale(d.smp, env_dl, m_dl);
    dr = env_scale(d.smp, env_dr, m_dr);
    wl = env_scale(dl, env_wet, m_wl);
    wr = env_scale(dr, env_wet, m_wr);
    r.dry_left  = clamp_add(d.dry_left_acc, dl);
    r.dry_right = clamp_add(d.dry_right_acc, dr);
    if (flags[FLAG_SWAP]) begin
      r.wet_left  = clamp_add(d.wet_left_acc, wr);
      r.wet_right = clamp_add(d.wet_right_acc, wl);
    end else begin
      r.wet_left  = clamp_add(d.wet_left_acc, wl);
      r.wet_right = clamp_add(d.wet_right_acc, wr);
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [SMP_W-1:0] want, logic [SMP_W-1:0] got);
    if (want !== got) begin
      if (fail_count < 10) begin
        $display("%t mismatch %s: expected %h actual %h", $realtime, name, want, got);
      end
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    mix_sums_t want, got;
    if (rst) begin
      {start_dl, start_dr, start_wet} <= '0;
      {step_dl, step_dr, step_wet}    <= '0;
      flags                           <= '0;
      {env_dl, env_dr, env_wet}       <= '0;
      group_pos = 0;
      fail_count = 0;
      expected_sums.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = mix_sums_t'(m_tdata);
        if (expected_sums.size() == 0) begin
          if (fail_count < 10) begin
            $display("%t unexpected result transfer %h", $realtime, m_tdata);
          end
          fail_count++;
        end else begin
          want = expected_sums.pop_front();
          check_field("dry_left_sum",  want.dry_left,  got.dry_left);
          check_field("dry_right_sum", want.dry_right, got.dry_right);
          check_field("wet_left_sum",  want.wet_left,  got.wet_left);
          check_field("wet_right_sum", want.wet_right, got.wet_right);
        end
      end
      if (s_tvalid && s_tready) begin
        expected_sums.push_back(predict_sums(mix_in_t'(s_tdata)));
        group_pos++;
        // group filled or block ended early: envelopes step
        if (group_pos >= GROUP_SIZE || s_tlast) begin
          group_pos = 0;
          env_dl  <= env_dl + step_dl;
          env_dr  <= env_dr + step_dr;
          env_wet <= env_wet + step_wet;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ENV_DL:  start_dl  <= cfg_data;
          REG_ENV_DR:  start_dr  <= cfg_data;
          REG_ENV_WET: start_wet <= cfg_data;
          REG_STEP_DL: step_dl   <= cfg_data;
          REG_STEP_DR: step_dr   <= cfg_data;
          REG_STEP_WT: step_wet  <= cfg_data;
          REG_FLAGS:   flags     <= cfg_data[FLAG_W-1:0];
          default: ;
        endcase
        // any valid write reloads the envelopes, including the new value
        if (cfg_index <= REG_FLAGS) begin
          env_dl  <= (cfg_index == REG_ENV_DL)  ? cfg_data : start_dl;
          env_dr  <= (cfg_index == REG_ENV_DR)  ? cfg_data : start_dr;
          env_wet <= (cfg_index == REG_ENV_WET) ? cfg_data : start_wet;
        end
      end
    end
    pending <= expected_sums.size();
    errors  <= fail_count;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the envelope stereo wet/dry mixer: directed edge
// samples, then randomised blocks of eight-sample groups under several
// register settings, with random idling on both streams and one long
// receiver hold-off; the checker beside the block does all comparison
// ----------------------------------------------------------------------------
module testbench;
  import eswdm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GROUP = 8;
  // an index past the register list, writes there must do nothing
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;
  localparam int HOLD_CYCLES = 400;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [ENV_W-1:0] cfg_data;
  logic             s_tvalid;
  logic             s_tready;
  logic [79:0]      s_tdata;  // sample, dry_left_acc, dry_right_acc, wet_left_acc, wet_right_acc
  logic             s_tlast;  // block_end
  logic             m_tvalid;
  logic             m_tready;
  logic [63:0]      m_tdata;  // dry_left_sum, dry_right_sum, wet_left_sum, wet_right_sum
  int               errors;
  int               pending;

  // idling switch for both sides, and the one-off long receiver hold-off
  bit idle_on;
  bit long_hold;

  envelope_stereo_wet_dry_mixer_top #(
    .GROUP_SIZE(GROUP)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  mix_checker #(
    .GROUP_SIZE(GROUP)
  ) mix_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #3ms;
    $display("testbench: errors");
    $finish;
  end

  // result side: random stall bursts, or one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        // counted hold, the sender keeps offering so the block backs up
        for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
        long_hold = 1'b0;
        m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // biased towards the extremes of a 16-bit field
  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one input transfer; valid may stay high straight into the next sample
  task automatic send_sample(input logic [15:0] smp, input logic [15:0] dl,
                             input logic [15:0] dr, input logic [15:0] wl,
                             input logic [15:0] wr, input logic last);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {wr, wl, dr, dl, smp};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_random(input logic last);
    send_sample(pick16(), pick16(), pick16(), pick16(), pick16(), last);
  endtask

  // stop offering and let every outstanding result drain
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] edl, input logic [15:0] edr,
                           input logic [15:0] ewet, input logic [15:0] sdl,
                           input logic [15:0] sdr, input logic [15:0] swet,
                           input logic [15:0] fl);
    settle();
    write_reg(REG_ENV_DL,  edl);
    write_reg(REG_ENV_DR,  edr);
    write_reg(REG_ENV_WET, ewet);
    write_reg(REG_STEP_DL, sdl);
    write_reg(REG_STEP_DR, sdr);
    write_reg(REG_STEP_WT, swet);
    write_reg(REG_FLAGS,   fl);
  endtask

  task automatic configure_random();
    configure(pick16(), pick16(), pick16(), pick16(), pick16(), pick16(),
              16'($urandom));
  endtask

  // mostly whole blocks of groups with the end marked, some broken runs
  task automatic run_blocks(input int n_items);
    int sent;
    int len;
    bit whole;
    sent = 0;
    while (sent < n_items) begin
      whole = ($urandom_range(0, 9) < 8);
      len   = whole ? GROUP * $urandom_range(1, 4) : $urandom_range(1, 12);
      for (int i = 0; i < len && sent < n_items; i++) begin
        if (whole) begin
          send_random(i == len - 1);
        end else begin
          send_random($urandom_range(0, 2) == 0);
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    idle_on   = 1'b1;
    long_hold = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: full-scale, half-scale and near-full gains, no inversion
    configure(16'hFFFF, 16'h8000, 16'hFF00, 16'h0001, 16'hFFFF, 16'h0100, 16'h0000);
    send_sample(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    // both saturation directions, block end part way through a group
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    send_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_sample(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 1'b0);
    // finish the group so the envelopes step on the count alone
    repeat (3) send_random(1'b0);
    repeat (GROUP) send_random(1'b0);

    // every mask and the swap, flag bits above the register width set
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h0001, 16'hFFFF, 16'hFFFF);
    send_sample(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);

    // write past the register list: no reload, envelopes keep their step
    settle();
    write_reg(REG_NONE, 16'hFFFF);
    send_sample(16'hFFFF, 16'h1234, 16'hEDCB, 16'h0000, 16'h7FFF, 1'b0);
    send_sample(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);

    // all registers at their low extreme, then at their high extreme
    configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_blocks(60);
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h001F);
    run_blocks(80);

    // random settings with idling on both sides
    for (int p = 0; p < 8; p++) begin
      configure_random();
      if (p == 3) begin
        // block fills up behind a stalled result stream
        long_hold = 1'b1;
      end
      run_blocks(90);
    end

    // closing stretch without any idling
    idle_on = 1'b0;
    for (int p = 0; p < 2; p++) begin
      configure_random();
      run_blocks(80);
    end

    settle();
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== envelope_stereo_wet_dry_mixer_top.f =====
+incdir+rtl
rtl/eswdm_pkg.sv
rtl/eswdm_ctrl.sv
rtl/eswdm_datapath.sv
rtl/envelope_stereo_wet_dry_mixer_top.sv
rtl/eswdm_checker.sv
tb/sv/mix_checker.sv
tb/sv/testbench.sv
